// ----- sv/tlvhp_pkg.sv -----
// Shared types and constants for the TLV header parser.
// No dependencies; imported by tlvhp_step and tlv_header_parser_core.
package tlvhp_pkg;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_TAG1  = 8'b0000_0001,
    PH_TAG2  = 8'b0000_0010,
    PH_LEN1  = 8'b0000_0100,
    PH_LENX1 = 8'b0000_1000,
    PH_LENHI = 8'b0001_0000,
    PH_LENLO = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_DROP  = 8'b1000_0000
  } phase_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Tag and length encodings
  localparam logic [7:0] BER_TAG_MASK = 8'h1f;
  localparam logic [7:0] BER_LEN_1B   = 8'h81;
  localparam logic [7:0] BER_LEN_2B   = 8'h82;
  localparam logic [7:0] SIMPLE_LEN_X = 8'hff;
  localparam logic [2:0] HDR_MAX      = 3'd5;

  localparam int unsigned RES_W  = 29;
  localparam int unsigned ODATA_W = 32;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  tag;
    logic [15:0] len;
    logic [15:0] rem;
    logic [2:0]  hdr;
  } pstate_t;

  // One result record; tag sits in the lowest bits
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  hdr;
    logic [15:0] len;
    logic [7:0]  tag;
  } result_t;

endpackage

// ----- sv/tlvhp_step.sv -----
// Per-byte parse step: next parser state and an optional result record.
// Pure combinational logic; depends on tlvhp_pkg.
module tlvhp_step
  import tlvhp_pkg::*;
(
  input  pstate_t    cur_i,
  input  logic [7:0] byte_i,
  input  logic       fin_i,
  input  logic       ber_i,
  output pstate_t    nxt_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [2:0] hdr_bump;
  logic       done;
  logic       bad;
  logic       set_len;
  logic [15:0] new_len;
  logic [15:0] rem_dec;

  assign hdr_bump = (cur_i.hdr < HDR_MAX) ? cur_i.hdr + 3'd1 : cur_i.hdr;
  assign rem_dec  = (cur_i.rem != 16'd0) ? cur_i.rem - 16'd1 : cur_i.rem;

  // Decode the byte against the current phase
  always_comb begin
    nxt_o   = cur_i;
    done    = 1'b0;
    bad     = 1'b0;
    set_len = 1'b0;
    new_len = {8'd0, byte_i};
    unique case (cur_i.phase)
      PH_TAG1: begin
        nxt_o.hdr = 3'd1;
        nxt_o.len = 16'd0;
        nxt_o.rem = 16'd0;
        if (ber_i && ((byte_i & BER_TAG_MASK) == BER_TAG_MASK)) begin
          nxt_o.tag   = 8'd0;
          nxt_o.phase = PH_TAG2;
        end else begin
          nxt_o.tag   = ber_i ? (byte_i & BER_TAG_MASK) : byte_i;
          nxt_o.phase = PH_LEN1;
        end
      end
      PH_TAG2: begin
        nxt_o.hdr   = hdr_bump;
        nxt_o.tag   = byte_i;
        nxt_o.phase = PH_LEN1;
      end
      PH_LEN1: begin
        nxt_o.hdr = hdr_bump;
        if (ber_i && byte_i[7]) begin
          if (byte_i == BER_LEN_1B) begin
            nxt_o.phase = PH_LENX1;
          end else if (byte_i == BER_LEN_2B) begin
            nxt_o.phase = PH_LENHI;
          end else begin
            bad         = 1'b1;
            nxt_o.phase = fin_i ? PH_TAG1 : PH_DROP;
          end
        end else if (!ber_i && (byte_i == SIMPLE_LEN_X)) begin
          nxt_o.phase = PH_LENHI;
        end else begin
          set_len = 1'b1;
        end
      end
      PH_LENX1: begin
        nxt_o.hdr = hdr_bump;
        set_len   = 1'b1;
      end
      PH_LENHI: begin
        nxt_o.hdr   = hdr_bump;
        nxt_o.len   = {byte_i, 8'd0};
        nxt_o.phase = PH_LENLO;
      end
      PH_LENLO: begin
        nxt_o.hdr = hdr_bump;
        new_len   = {cur_i.len[15:8], byte_i};
        set_len   = 1'b1;
      end
      PH_DATA: begin
        nxt_o.rem = rem_dec;
        if (rem_dec == 16'd0) begin
          nxt_o.phase = PH_TAG1;
          done        = 1'b1;
        end
      end
      PH_DROP: begin
        if (fin_i) nxt_o.phase = PH_TAG1;
      end
      default: begin
        nxt_o.phase = PH_TAG1;
      end
    endcase

    // Length known: zero length completes the record at once
    if (set_len) begin
      nxt_o.len = new_len;
      nxt_o.rem = new_len;
      if (new_len == 16'd0) begin
        nxt_o.phase = PH_TAG1;
        done        = 1'b1;
      end else begin
        nxt_o.phase = PH_DATA;
      end
    end

    // Buffer ends inside a record
    if (fin_i && !done && !bad && (cur_i.phase != PH_DROP)) begin
      nxt_o.phase = PH_TAG1;
    end
  end

  // Build the result record
  always_comb begin
    res_o.tag    = nxt_o.tag;
    res_o.hdr    = nxt_o.hdr;
    res_o.len    = bad ? 16'd0 : nxt_o.len;
    res_o.status = bad ? ST_BAD : (done ? ST_OK : ST_SHORT);
    res_valid_o  = bad || done || (fin_i && (cur_i.phase != PH_DROP));
  end

endmodule

// ----- sv/tlv_header_parser_core.sv -----
// TLV header parser top level: stream ports, parser state and result register.
// Depends on tlvhp_pkg and tlvhp_step.
//
// Usage: message bytes enter on the s_axis channel, one byte per transfer,
// with s_axis_tlast marking the final byte of a buffer. For each record the
// block issues one transfer on m_axis holding tag, value length, header byte
// count and status (ok, too few bytes, bad length form). Data bytes are only
// counted, never passed on. cfg_we_i with cfg_ber_mode_i selects BER (1) or
// simple (0) rules; write it only while the block is idle.
// Throughput: one byte per cycle while s_axis_tready is high. Each byte is parsed by a
// single layer of logic on the parser state; a result is visible on m_axis in the cycle
// after the transfer of the byte that ends the record.
// Reset (rst_ni low, asynchronous): simple mode, parser expects a first tag
// byte, result register empty.
// Stall: the result register holds while m_axis_tready is low; input bytes
// are still taken as long as the register is empty or being drained, else
// s_axis_tready drops until the result is taken.
module tlv_header_parser_core
  import tlvhp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_ber_mode_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,   // final_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ODATA_W-1:0] m_axis_tdata    // [7:0] tag_value, [23:8] value_length,
                                             // [26:24] header_bytes, [28:27] parse_status
);

  logic    ber_q;
  pstate_t st_q, st_d;
  logic    ovalid_q;
  result_t ores_q;
  logic    res_valid;
  result_t res;
  logic    in_xfer;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  tlvhp_step u_step (
    .cur_i      (st_q),
    .byte_i     (s_axis_tdata),
    .fin_i      (s_axis_tlast),
    .ber_i      (ber_q),
    .nxt_o      (st_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ber_q <= 1'b0;
    end else if (cfg_we_i) begin
      ber_q <= cfg_ber_mode_i;
    end
  end

  // Advance parser state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= PH_TAG1;
      st_q.tag   <= 8'd0;
      st_q.len   <= 16'd0;
      st_q.rem   <= 16'd0;
      st_q.hdr   <= 3'd0;
    end else if (in_xfer) begin
      st_q <= st_d;
    end
  end

  // Result register: load on a result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (in_xfer && res_valid) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      ores_q <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(ODATA_W - RES_W){1'b0}}, ores_q};

endmodule
